// ----- rtl/core/tllw_pkg.sv -----
// ----------------------------------------------------------------------------
// Text line layout package
// Shared constants for the line wrapping and alignment block.
// ----------------------------------------------------------------------------
package tllw_pkg;

    localparam int LINE_CHARS = 32;
    localparam int IDX_W      = $clog2(LINE_CHARS);
    localparam int CNT_W      = $clog2(LINE_CHARS + 1);

    localparam int CODE_W  = 8;
    localparam int GLYPH_W = 12;
    localparam int GAP_W   = 8;
    localparam int ALIGN_W = 3;
    localparam int ADV_W   = 13;
    localparam int PW_W    = 16;
    localparam int TOT_W   = 17;
    localparam int HGT_W   = 13;
    localparam int TOP_W   = 20;
    localparam int DCNT_W  = $clog2(PW_W);

    localparam logic [CODE_W-1:0]  CODE_LF = 8'd10;
    localparam logic [CODE_W-1:0]  CODE_CR = 8'd13;

    localparam logic [ALIGN_W-1:0] ALIGN_RIGHT  = 3'd2;
    localparam logic [ALIGN_W-1:0] ALIGN_CENTER = 3'd3;
    localparam logic [ALIGN_W-1:0] ALIGN_DIST   = 3'd4;

    localparam logic [PW_W-1:0]  PAGE_WIDTH_RESET = 16'd1024;
    localparam logic [PW_W-1:0]  MAX_X            = '1;
    localparam logic [TOP_W-1:0] MAX_Y            = '1;

endpackage

// ----- rtl/core/text_line_layout_wrap.sv -----
// A character that closes no line passes S_DECIDE, S_APPEND, S_POST and S_TAIL.
// A line flush adds S_FSTART and S_FEND, the bit-serial divider in S_DIV on
// distributed lines, and S_RD and S_OUT per placed character from the line buffer.
// One input transaction is processed at a time; the input is stalled meanwhile.
// Reset is synchronous and active low; it empties the line and restores the
// page width to 1024. The line buffer holds no reset value.
// ----------------------------------------------------------------------------
// Text line layout with wrapping
// Buffers one line of characters, breaks greedily on page width, line end
// codes, a full buffer or end of text, and places each character with
// left, right, center or distributed alignment.
// ----------------------------------------------------------------------------
module text_line_layout_wrap (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_char_code,
    input  logic [11:0] i_glyph_width,
    input  logic [11:0] i_glyph_height,
    input  logic [7:0]  i_char_gap,
    input  logic [7:0]  i_line_gap,
    input  logic [2:0]  i_align_mode,
    input  logic        i_end_of_text,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_char,
    output logic [15:0] o_pos_x,
    output logic [19:0] o_pos_y,
    output logic [15:0] o_box_width,
    output logic [12:0] o_box_height,
    output logic        o_last
);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_DECIDE = 10'b00_0000_0010,
        S_FSTART = 10'b00_0000_0100,
        S_DIV    = 10'b00_0000_1000,
        S_RD     = 10'b00_0001_0000,
        S_OUT    = 10'b00_0010_0000,
        S_FEND   = 10'b00_0100_0000,
        S_APPEND = 10'b00_1000_0000,
        S_POST   = 10'b01_0000_0000,
        S_TAIL   = 10'b10_0000_0000
    } t_state;

    typedef struct packed {
        logic [tllw_pkg::CODE_W-1:0] code;
        logic [tllw_pkg::ADV_W-1:0]  adv;
    } t_entry;

    t_state r_state;
    t_state r_ret;

    logic [tllw_pkg::PW_W-1:0]    r_pw;
    logic [tllw_pkg::CNT_W-1:0]   r_count;
    logic [tllw_pkg::TOT_W-1:0]   r_total;
    logic [tllw_pkg::HGT_W-1:0]   r_maxh;
    logic [tllw_pkg::ALIGN_W-1:0] r_align;
    logic [tllw_pkg::TOP_W-1:0]   r_top;
    logic                         r_o_valid;

    logic [tllw_pkg::CODE_W-1:0]  r_code;
    logic [tllw_pkg::ADV_W-1:0]   r_adv;
    logic [tllw_pkg::HGT_W-1:0]   r_h;
    logic [tllw_pkg::ALIGN_W-1:0] r_in_align;
    logic                         r_eot;
    logic                         r_more;

    logic [tllw_pkg::PW_W-1:0]    r_x;
    logic [tllw_pkg::CNT_W-1:0]   r_idx;
    logic [tllw_pkg::PW_W-1:0]    r_quot;
    logic [tllw_pkg::CNT_W-1:0]   r_rem;
    logic [tllw_pkg::DCNT_W-1:0]  r_div_cnt;

    t_entry r_mem [tllw_pkg::LINE_CHARS];
    t_entry r_rd_data;

    logic [7:0]  r_out_char;
    logic [15:0] r_pos_x;
    logic [19:0] r_pos_y;
    logic [15:0] r_box_width;
    logic [12:0] r_box_height;
    logic        r_last;

    logic                          w_accept;
    logic                          w_is_eol;
    logic [tllw_pkg::TOT_W:0]      w_adv_sum;
    logic                          w_over;
    logic                          w_full;
    logic                          w_adv_big;
    logic                          w_oversize;
    logic [tllw_pkg::PW_W-1:0]     w_room;
    logic [tllw_pkg::CNT_W:0]      w_rem_sh;
    logic                          w_div_ge;
    logic [tllw_pkg::CNT_W:0]      w_rem_sub;
    logic [tllw_pkg::PW_W:0]       w_bw_sum;
    logic [tllw_pkg::PW_W-1:0]     w_bw;
    logic [tllw_pkg::PW_W:0]       w_x_sum;
    logic [tllw_pkg::CNT_W-1:0]    w_idx_nxt;
    logic                          w_last_char;
    logic                          w_out_free;
    logic                          w_out_load;
    logic [tllw_pkg::TOP_W:0]      w_top_sum;
    logic [tllw_pkg::TOT_W-1:0]    w_total_nxt;
    logic [tllw_pkg::ALIGN_W-1:0]  w_align;

    assign w_accept   = i_valid && (r_state == S_IDLE);
    assign w_is_eol   = (r_code == tllw_pkg::CODE_LF) || (r_code == tllw_pkg::CODE_CR);
    assign w_adv_sum  = {1'b0, r_total} + (tllw_pkg::TOT_W + 1)'(r_adv);
    assign w_over     = w_adv_sum > (tllw_pkg::TOT_W + 1)'(r_pw);
    assign w_full     = r_count >= tllw_pkg::CNT_W'(tllw_pkg::LINE_CHARS);
    assign w_adv_big  = tllw_pkg::TOT_W'(r_adv) > tllw_pkg::TOT_W'(r_pw);
    assign w_oversize = (r_count == tllw_pkg::CNT_W'(1)) &&
                        (r_total > tllw_pkg::TOT_W'(r_pw));
    assign w_room     = (r_total < tllw_pkg::TOT_W'(r_pw)) ?
                        (r_pw - r_total[tllw_pkg::PW_W-1:0]) : '0;

    assign w_rem_sh  = {r_rem, r_quot[tllw_pkg::PW_W-1]};
    assign w_div_ge  = w_rem_sh >= {1'b0, r_count};
    assign w_rem_sub = w_rem_sh - {1'b0, r_count};

    assign w_bw_sum    = (tllw_pkg::PW_W + 1)'(r_rd_data.adv) + {1'b0, r_quot};
    assign w_bw        = w_bw_sum[tllw_pkg::PW_W] ? tllw_pkg::MAX_X :
                         w_bw_sum[tllw_pkg::PW_W-1:0];
    assign w_x_sum     = {1'b0, r_x} + {1'b0, w_bw};
    assign w_idx_nxt   = r_idx + tllw_pkg::CNT_W'(1);
    assign w_last_char = w_idx_nxt == r_count;
    assign w_out_free  = !r_o_valid || !i_stall;
    assign w_out_load  = (r_state == S_OUT) && w_out_free;
    assign w_top_sum   = {1'b0, r_top} + (tllw_pkg::TOP_W + 1)'(r_maxh);
    assign w_total_nxt = r_total + tllw_pkg::TOT_W'(r_adv);
    assign w_align     = (r_count == '0) ? r_in_align : r_align;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pw      <= tllw_pkg::PAGE_WIDTH_RESET;
            r_count   <= '0;
            r_total   <= '0;
            r_maxh    <= '0;
            r_align   <= '0;
            r_top     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_pw <= i_cfg_wr_data;
            end
            if (w_out_load) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    if (w_is_eol) begin
                        r_state <= S_FSTART;
                    end else if ((r_count != '0) && (w_over || w_full)) begin
                        r_state <= S_FSTART;
                    end else begin
                        r_state <= S_APPEND;
                    end
                end
                S_FSTART: begin
                    if (r_count == '0) begin
                        r_state <= S_FEND;
                    end else if (r_align == tllw_pkg::ALIGN_DIST) begin
                        r_state <= S_DIV;
                    end else begin
                        r_state <= S_RD;
                    end
                end
                S_DIV: begin
                    if (r_div_cnt == tllw_pkg::DCNT_W'(tllw_pkg::PW_W - 1)) begin
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_state <= w_last_char ? S_FEND : S_RD;
                    end
                end
                S_FEND: begin
                    r_top   <= w_top_sum[tllw_pkg::TOP_W] ? tllw_pkg::MAX_Y :
                               w_top_sum[tllw_pkg::TOP_W-1:0];
                    r_count <= '0;
                    r_total <= '0;
                    r_maxh  <= '0;
                    r_align <= '0;
                    r_state <= r_ret;
                end
                S_APPEND: begin
                    r_align <= w_align;
                    r_count <= r_count + tllw_pkg::CNT_W'(1);
                    r_total <= w_total_nxt;
                    if (r_h > r_maxh) begin
                        r_maxh <= r_h;
                    end
                    r_state <= S_POST;
                end
                S_POST: begin
                    if (w_oversize || (r_eot && (r_count != '0))) begin
                        r_state <= S_FSTART;
                    end else begin
                        r_state <= S_TAIL;
                    end
                end
                S_TAIL: begin
                    if (r_eot) begin
                        r_top <= '0;
                    end
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[r_idx[tllw_pkg::IDX_W-1:0]];
        if (w_accept) begin
            r_code     <= i_char_code;
            r_adv      <= tllw_pkg::ADV_W'(i_glyph_width) + tllw_pkg::ADV_W'(i_char_gap);
            r_h        <= tllw_pkg::HGT_W'(i_glyph_height) + tllw_pkg::HGT_W'(i_line_gap);
            r_in_align <= i_align_mode;
            r_eot      <= i_end_of_text;
        end
        case (r_state)
            S_DECIDE: begin
                if (w_is_eol) begin
                    r_ret  <= S_TAIL;
                    r_more <= 1'b0;
                end else begin
                    r_ret  <= S_APPEND;
                    r_more <= r_eot || w_adv_big;
                end
            end
            S_POST: begin
                r_ret  <= S_TAIL;
                r_more <= 1'b0;
            end
            S_FSTART: begin
                if (r_align == tllw_pkg::ALIGN_RIGHT) begin
                    r_x <= w_room;
                end else if (r_align == tllw_pkg::ALIGN_CENTER) begin
                    r_x <= w_room >> 1;
                end else begin
                    r_x <= '0;
                end
                r_quot    <= (r_align == tllw_pkg::ALIGN_DIST) ? w_room : '0;
                r_rem     <= '0;
                r_div_cnt <= '0;
                r_idx     <= '0;
            end
            S_DIV: begin
                r_quot    <= {r_quot[tllw_pkg::PW_W-2:0], w_div_ge};
                r_rem     <= w_div_ge ? w_rem_sub[tllw_pkg::CNT_W-1:0] :
                                        w_rem_sh[tllw_pkg::CNT_W-1:0];
                r_div_cnt <= r_div_cnt + tllw_pkg::DCNT_W'(1);
            end
            S_OUT: begin
                if (w_out_free) begin
                    r_out_char   <= r_rd_data.code;
                    r_pos_x      <= r_x;
                    r_pos_y      <= r_top;
                    r_box_width  <= w_bw;
                    r_box_height <= r_maxh;
                    r_last       <= w_last_char && !r_more;
                    r_x          <= w_x_sum[tllw_pkg::PW_W] ? tllw_pkg::MAX_X :
                                    w_x_sum[tllw_pkg::PW_W-1:0];
                    r_idx        <= w_idx_nxt;
                end
            end
            S_APPEND: begin
                r_mem[r_count[tllw_pkg::IDX_W-1:0]] <= '{code: r_code, adv: r_adv};
            end
            default: begin
            end
        endcase
    end

    assign o_stall      = (r_state != S_IDLE);
    assign o_valid      = r_o_valid;
    assign o_out_char   = r_out_char;
    assign o_pos_x      = r_pos_x;
    assign o_pos_y      = r_pos_y;
    assign o_box_width  = r_box_width;
    assign o_box_height = r_box_height;
    assign o_last       = r_last;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= tllw_pkg::CNT_W'(tllw_pkg::LINE_CHARS))
        else $error("line character count exceeds buffer depth");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_count != '0))
        else $error("distributed spacing divides by an empty line");

    a_read_in_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> (r_idx < r_count))
        else $error("placement reads past the buffered line");

    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FEND) |=> (r_count == '0) && (r_total == '0))
        else $error("line state not cleared after flush");

endmodule

// ----- dv/text_line_layout_wrap_tb.sv -----
// ----------------------------------------------------------------------------
// Testbench for text_line_layout_wrap
// Character transactions are driven from a queue of pending characters.
// Each accepted character is run through a line layout predictor in the
// testbench, and every placed character that comes out is compared field by
// field with the oldest prediction. The run walks through several page widths
// and several idle and stall patterns, including a long receiver hold-off.
// ----------------------------------------------------------------------------
module text_line_layout_wrap_tb;

    localparam logic [tllw_pkg::ALIGN_W-1:0] ALIGN_NORMAL  = 3'd0;
    localparam logic [tllw_pkg::ALIGN_W-1:0] ALIGN_LEFT    = 3'd1;
    localparam logic [tllw_pkg::ALIGN_W-1:0] ALIGN_UNDEF_LO = 3'd5;
    localparam logic [tllw_pkg::ALIGN_W-1:0] ALIGN_UNDEF_HI = 3'd7;
    localparam int STUCK_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 64;
    localparam int MAX_REPORTS   = 10;

    typedef struct {
        logic [tllw_pkg::CODE_W-1:0]  code;
        logic [tllw_pkg::GLYPH_W-1:0] glyph_w;
        logic [tllw_pkg::GLYPH_W-1:0] glyph_h;
        logic [tllw_pkg::GAP_W-1:0]   char_gap;
        logic [tllw_pkg::GAP_W-1:0]   line_gap;
        logic [tllw_pkg::ALIGN_W-1:0] align;
        logic                         eot;
    } t_text_char;

    typedef struct {
        logic [tllw_pkg::CODE_W-1:0] code;
        logic [15:0]                 pos_x;
        logic [19:0]                 pos_y;
        logic [15:0]                 box_w;
        logic [12:0]                 box_h;
        logic                        last;
    } t_placed_char;

    logic i_clk;
    logic i_rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [tllw_pkg::PW_W-1:0] cfg_wr_data = '0;
    logic drv_valid = 1'b0;
    t_text_char drv_char = '{default: '0};
    logic rx_stall = 1'b0;
    logic in_fire = 1'b0;

    logic        o_stall;
    logic        o_valid;
    logic [7:0]  o_out_char;
    logic [15:0] o_pos_x;
    logic [19:0] o_pos_y;
    logic [15:0] o_box_width;
    logic [12:0] o_box_height;
    logic        o_last;

    t_text_char   pending_chars[$];
    t_placed_char placed_q[$];
    int chars_queued = 0;
    int chars_taken = 0;
    int mismatch_count = 0;
    int stuck_cycles = 0;
    int idle_pct = 0;
    int stall_pct = 0;
    int hold_left = 0;

    logic [tllw_pkg::CODE_W-1:0]  row_code[tllw_pkg::LINE_CHARS];
    int unsigned                  row_adv[tllw_pkg::LINE_CHARS];
    int unsigned                  row_count = 0;
    int unsigned                  row_width = 0;
    int unsigned                  row_height = 0;
    logic [tllw_pkg::ALIGN_W-1:0] row_align = ALIGN_NORMAL;
    int unsigned                  row_top = 0;
    int unsigned                  page_w = tllw_pkg::PAGE_WIDTH_RESET;

    text_line_layout_wrap i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_wr_data  (cfg_wr_data),
        .i_valid        (drv_valid),
        .o_stall        (o_stall),
        .i_char_code    (drv_char.code),
        .i_glyph_width  (drv_char.glyph_w),
        .i_glyph_height (drv_char.glyph_h),
        .i_char_gap     (drv_char.char_gap),
        .i_line_gap     (drv_char.line_gap),
        .i_align_mode   (drv_char.align),
        .i_end_of_text  (drv_char.eot),
        .o_valid        (o_valid),
        .i_stall        (rx_stall),
        .o_out_char     (o_out_char),
        .o_pos_x        (o_pos_x),
        .o_pos_y        (o_pos_y),
        .o_box_width    (o_box_width),
        .o_box_height   (o_box_height),
        .o_last         (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic int unsigned sat_x(input int unsigned v);
        return (v > 32'(tllw_pkg::MAX_X)) ? 32'(tllw_pkg::MAX_X) : v;
    endfunction

    function automatic void close_line();
        int unsigned room;
        int unsigned extra;
        int unsigned x;
        int unsigned bw;
        t_placed_char p;
        room = (page_w > row_width) ? page_w - row_width : 0;
        extra = 0;
        x = 0;
        if (row_align == tllw_pkg::ALIGN_RIGHT) begin
            x = room;
        end else if (row_align == tllw_pkg::ALIGN_CENTER) begin
            x = room >> 1;
        end else if (row_align == tllw_pkg::ALIGN_DIST && row_count != 0) begin
            extra = room / row_count;
        end
        for (int i = 0; i < int'(row_count); i++) begin
            bw = sat_x(row_adv[i] + extra);
            p.code = row_code[i];
            p.pos_x = 16'(sat_x(x));
            p.pos_y = 20'(row_top);
            p.box_w = 16'(bw);
            p.box_h = 13'(row_height);
            p.last = 1'b0;
            placed_q.insert(placed_q.size(), p);
            x = sat_x(x + bw);
        end
        row_top = row_top + row_height;
        if (row_top > 32'(tllw_pkg::MAX_Y)) begin
            row_top = 32'(tllw_pkg::MAX_Y);
        end
        row_count = 0;
        row_width = 0;
        row_height = 0;
        row_align = ALIGN_NORMAL;
    endfunction

    function automatic void lay_out_char(input t_text_char c);
        int unsigned adv;
        int unsigned h;
        int before_n;
        adv = 32'(c.glyph_w) + 32'(c.char_gap);
        h = 32'(c.glyph_h) + 32'(c.line_gap);
        before_n = placed_q.size();
        if (c.code == tllw_pkg::CODE_LF || c.code == tllw_pkg::CODE_CR) begin
            close_line();
        end else begin
            if (row_count != 0 &&
                (row_width + adv > page_w || row_count >= tllw_pkg::LINE_CHARS)) begin
                close_line();
            end
            if (row_count == 0) begin
                row_align = c.align;
            end
            row_code[row_count] = c.code;
            row_adv[row_count] = adv;
            row_count++;
            row_width += adv;
            if (h > row_height) begin
                row_height = h;
            end
            if (row_count == 1 && row_width > page_w) begin
                close_line();
            end
        end
        if (c.eot) begin
            if (row_count != 0) begin
                close_line();
            end
            row_top = 0;
        end
        if (placed_q.size() > before_n) begin
            placed_q[$].last = 1'b1;
        end
    endfunction

    function automatic void note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("ERROR: %s", msg);
        end
    endfunction

    always @(posedge i_clk) begin
        t_placed_char exp_char;
        logic took_any;
        if (i_rst_n) begin
            took_any = 1'b0;
            if (o_valid && !rx_stall) begin
                took_any = 1'b1;
                if (placed_q.size() == 0) begin
                    note_mismatch($sformatf(
                        "unexpected result char=%0d x=%0d y=%0d w=%0d h=%0d last=%0b",
                        o_out_char, o_pos_x, o_pos_y, o_box_width, o_box_height, o_last));
                end else begin
                    exp_char = placed_q.pop_front();
                    if (o_out_char !== exp_char.code || o_pos_x !== exp_char.pos_x ||
                        o_pos_y !== exp_char.pos_y || o_box_width !== exp_char.box_w ||
                        o_box_height !== exp_char.box_h || o_last !== exp_char.last) begin
                        note_mismatch($sformatf(
                            {"exp char=%0d x=%0d y=%0d w=%0d h=%0d last=%0b, ",
                             "got char=%0d x=%0d y=%0d w=%0d h=%0d last=%0b"},
                            exp_char.code, exp_char.pos_x, exp_char.pos_y, exp_char.box_w,
                            exp_char.box_h, exp_char.last, o_out_char, o_pos_x, o_pos_y,
                            o_box_width, o_box_height, o_last));
                    end
                end
            end
            if (drv_valid && !o_stall) begin
                took_any = 1'b1;
                lay_out_char(drv_char);
                chars_taken++;
            end
            in_fire <= drv_valid && !o_stall;
            if (took_any) begin
                stuck_cycles = 0;
            end else begin
                stuck_cycles++;
            end
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("text_line_layout_wrap test failed");
                $finish;
            end
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n && (!drv_valid || in_fire)) begin
            if (pending_chars.size() != 0 && $urandom_range(99) >= idle_pct) begin
                drv_char <= pending_chars.pop_front();
                drv_valid <= 1'b1;
            end else begin
                drv_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            rx_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else begin
            rx_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    function automatic t_text_char mk(input int code, input int gw, input int gh,
                                      input int cg, input int lg,
                                      input logic [tllw_pkg::ALIGN_W-1:0] al,
                                      input bit eot);
        t_text_char c;
        c.code = 8'(code);
        c.glyph_w = 12'(gw);
        c.glyph_h = 12'(gh);
        c.char_gap = 8'(cg);
        c.line_gap = 8'(lg);
        c.align = al;
        c.eot = eot;
        return c;
    endfunction

    function automatic t_text_char rand_char(input int max_w);
        t_text_char c;
        c.code = 8'($urandom_range(255));
        c.glyph_w = ($urandom_range(19) == 0) ? 12'($urandom_range(4095))
                                              : 12'($urandom_range(max_w));
        c.glyph_h = 12'($urandom_range(4095));
        c.char_gap = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(3));
        c.line_gap = 8'($urandom_range(255));
        c.align = 3'($urandom_range(7));
        c.eot = ($urandom_range(99) == 0);
        return c;
    endfunction

    function automatic void push_char(input t_text_char c);
        pending_chars.insert(pending_chars.size(), c);
        chars_queued++;
    endfunction

    task automatic queue_lines(input int n_items, input int max_w);
        t_text_char c;
        int len;
        int r;
        while (n_items > 0) begin
            len = $urandom_range(40, 1);
            r = $urandom_range(99);
            for (int i = 0; i < len && n_items > 0; i++) begin
                c = rand_char(max_w);
                if (i == len - 1 && r < 30) begin
                    c.eot = 1'b1;
                end
                push_char(c);
                n_items--;
            end
            if (r >= 30 && r < 75 && n_items > 0) begin
                c = rand_char(max_w);
                c.code = $urandom_range(1) ? tllw_pkg::CODE_LF : tllw_pkg::CODE_CR;
                push_char(c);
                n_items--;
            end
        end
    endtask

    task automatic wait_drained();
        do begin
            @(negedge i_clk);
        end while (chars_taken != chars_queued || placed_q.size() != 0);
    endtask

    task automatic start_phase(input logic [tllw_pkg::PW_W-1:0] pw, input int idle,
                               input int stall);
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= pw;
        @(negedge i_clk);
        cfg_wr_en <= 1'b0;
        page_w = pw;
        @(posedge i_clk);
        idle_pct = idle;
        stall_pct = stall;
    endtask

    initial begin
        t_text_char c;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        push_char(mk(65, 0, 0, 0, 0, ALIGN_NORMAL, 0));
        push_char(mk(66, 4095, 4095, 255, 255, ALIGN_LEFT, 0));
        push_char(mk(tllw_pkg::CODE_LF, 0, 0, 0, 0, ALIGN_NORMAL, 0));
        push_char(mk(tllw_pkg::CODE_CR, 4095, 4095, 255, 255, ALIGN_UNDEF_HI, 0));
        push_char(mk(67, 100, 20, 5, 2, tllw_pkg::ALIGN_RIGHT, 0));
        push_char(mk(68, 50, 30, 0, 0, ALIGN_LEFT, 0));
        push_char(mk(tllw_pkg::CODE_CR, 1, 1, 1, 1, ALIGN_NORMAL, 0));
        push_char(mk(69, 200, 10, 3, 1, tllw_pkg::ALIGN_CENTER, 0));
        push_char(mk(70, 201, 10, 0, 0, ALIGN_NORMAL, 0));
        push_char(mk(tllw_pkg::CODE_LF, 0, 0, 0, 0, ALIGN_NORMAL, 0));
        push_char(mk(71, 10, 40, 1, 0, tllw_pkg::ALIGN_DIST, 0));
        push_char(mk(72, 13, 12, 2, 9, tllw_pkg::ALIGN_RIGHT, 0));
        push_char(mk(73, 7, 3, 0, 0, ALIGN_NORMAL, 0));
        push_char(mk(tllw_pkg::CODE_LF, 0, 0, 0, 0, ALIGN_NORMAL, 0));
        push_char(mk(74, 1000, 8, 0, 0, tllw_pkg::ALIGN_DIST, 0));
        push_char(mk(75, 24, 8, 0, 0, ALIGN_NORMAL, 0));
        push_char(mk(76, 1, 5, 0, 0, ALIGN_UNDEF_LO, 0));
        push_char(mk(77, 1, 6, 0, 0, ALIGN_UNDEF_HI, 1));
        push_char(mk(78, 5, 4, 0, 0, tllw_pkg::ALIGN_RIGHT, 0));
        push_char(mk(tllw_pkg::CODE_LF, 0, 0, 0, 0, ALIGN_NORMAL, 1));
        push_char(mk(80, 1500, 30, 0, 0, tllw_pkg::ALIGN_CENTER, 0));
        push_char(mk(255, 3, 2, 1, 1, tllw_pkg::ALIGN_RIGHT, 0));
        push_char(mk(0, 4, 2, 1, 1, ALIGN_NORMAL, 1));

        start_phase(16'hFFFF, 0, 0);
        hold_left = 600;
        queue_lines(60, 40);

        start_phase(16'd300, 85, 0);
        queue_lines(60, 30);

        start_phase(16'($urandom_range(2000, 1)), 0, 85);
        queue_lines(60, 100);

        start_phase(16'd1, 7, 7);
        for (int i = 0; i < 260; i++) begin
            c = rand_char(4095);
            c.code = 8'($urandom_range(255, 14));
            c.glyph_w = 12'($urandom_range(4095, 2));
            c.glyph_h = 12'($urandom_range(4095, 3900));
            c.line_gap = 8'($urandom_range(255, 200));
            c.eot = (i == 259);
            push_char(c);
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (mismatch_count == 0 && placed_q.size() == 0) begin
            $display("text_line_layout_wrap test passed");
        end else begin
            $display("text_line_layout_wrap test failed");
        end
        $finish;
    end

endmodule
